// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the tangent generator.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define TTG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a condition on the next clock edge.
`define TTG_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ttg_pkg.sv =====
// Types, state codes and constants of the tangent generator.
// No dependencies; used by the MAC, the root/divide unit and the top level.
package ttg_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned UNIT_WIDTH_DEF  = 16;

  localparam int unsigned WORK_W  = 64;
  localparam int unsigned FIT_W   = 32;
  localparam int unsigned MAC_A_W = 36;
  localparam int unsigned MAC_B_W = 32;
  localparam int unsigned ROOT_W  = 32;

  localparam logic [WORK_W-1:0] FIT_HI    = 64'h0000_0000_4000_0000;
  localparam logic [WORK_W-1:0] FIT_LO    = 64'h0000_0000_2000_0000;
  localparam logic [WORK_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  localparam logic [1:0] LAST_SLOT = 2'd2;

  typedef logic signed [WORK_W-1:0]  work_t;
  typedef logic signed [FIT_W-1:0]   fit_t;
  typedef logic signed [MAC_A_W-1:0] mac_a_t;
  typedef logic signed [MAC_B_W-1:0] mac_b_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_DELTA  = 10'b00_0000_0010,
    ST_FMAX   = 10'b00_0000_0100,
    ST_FNORM  = 10'b00_0000_1000,
    ST_FAPPLY = 10'b00_0001_0000,
    ST_FDONE  = 10'b00_0010_0000,
    ST_MAC    = 10'b00_0100_0000,
    ST_SQRT   = 10'b00_1000_0000,
    ST_DIV    = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } state_e;

  typedef enum logic [3:0] {
    PH_EDGE = 4'b0001,
    PH_UV   = 4'b0010,
    PH_TAN  = 4'b0100,
    PH_PROJ = 4'b1000
  } phase_e;

  typedef enum logic [3:0] {
    PG_FACE = 4'b0001,
    PG_DOT  = 4'b0010,
    PG_PROJ = 4'b0100,
    PG_LEN  = 4'b1000
  } prog_e;

  typedef enum logic [1:0] {
    IT_SQRT = 2'b01,
    IT_DIV  = 2'b10
  } it_mode_e;

  typedef struct packed {
    logic   go;
    logic   clr;
    logic   neg;
    mac_a_t a;
    mac_b_t b;
  } mac_op_t;

  typedef struct packed {
    logic     go;
    it_mode_e mode;
  } it_req_t;

endpackage

// ===== rtl/ttg_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on ttg_pkg.
module ttg_mac (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ttg_pkg::mac_op_t op_i,
  output ttg_pkg::work_t   acc_o
);

  localparam int unsigned PROD_W = ttg_pkg::MAC_A_W + ttg_pkg::MAC_B_W;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     pv_q, pclr_q, pneg_q;
  ttg_pkg::work_t           term, acc_d, acc_q;

  assign prod_d = $signed(op_i.a) * $signed(op_i.b);

  always_comb begin
    term  = pneg_q ? -ttg_pkg::work_t'(prod_q) : ttg_pkg::work_t'(prod_q);
    acc_d = acc_q;
    if (pv_q) begin
      acc_d = pclr_q ? term : acc_q + term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      pclr_q <= 1'b0;
      pneg_q <= 1'b0;
    end else begin
      pv_q   <= op_i.go;
      pclr_q <= op_i.clr;
      pneg_q <= op_i.neg;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/ttg_root_div.sv =====
// Bit-serial unit shared by the integer square root and the restoring divide.
// Depends on ttg_pkg.
module ttg_root_div #(
  parameter int unsigned QW = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ttg_pkg::it_req_t            req_i,
  input  logic [ttg_pkg::WORK_W-1:0]  x_i,
  input  logic [ttg_pkg::WORK_W-1:0]  d_i,
  output logic                        done_o,
  output logic [ttg_pkg::ROOT_W-1:0]  res_o
);

  localparam int unsigned W = ttg_pkg::WORK_W;

  logic [W-1:0]       rem_q, rem_d, bit_q, bit_d, root_q, root_d, sub, diff;
  logic               ge;
  logic [5:0]         cnt_q, cnt_d;
  logic               run_q, run_d, done_q, done_d;
  ttg_pkg::it_mode_e  mode_q, mode_d;

  assign sub  = (mode_q == ttg_pkg::IT_SQRT) ? root_q + bit_q : bit_q;
  assign diff = rem_q - sub;
  assign ge   = rem_q >= sub;

  always_comb begin
    rem_d  = rem_q;
    bit_d  = bit_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    mode_d = mode_q;
    done_d = 1'b0;
    if (req_i.go) begin
      run_d  = 1'b1;
      mode_d = req_i.mode;
      rem_d  = x_i;
      root_d = '0;
      if (req_i.mode == ttg_pkg::IT_SQRT) begin
        bit_d = ttg_pkg::SQRT_BIT0;
        cnt_d = 6'd31;
      end else begin
        bit_d = d_i << (QW - 1);
        cnt_d = 6'(QW - 1);
      end
    end else if (run_q) begin
      if (ge) begin
        rem_d = diff;
      end
      if (mode_q == ttg_pkg::IT_SQRT) begin
        root_d = ge ? (root_q >> 1) + bit_q : root_q >> 1;
        bit_d  = bit_q >> 2;
      end else begin
        root_d = {root_q[W-2:0], ge};
        bit_d  = bit_q >> 1;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= ttg_pkg::IT_SQRT;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign res_o  = root_q[ttg_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/triangle_tangent_generator.sv =====
// Top level of the per-triangle tangent generator: vertex store, sequencer, fit logic.
// Depends on ttg_pkg, ttg_mac, ttg_root_div and assert_macros.svh.
`include "assert_macros.svh"

// Usage: present one vertex per request (start high while busy is low). The
// first two vertices of a triangle are only stored and produce nothing. The
// third vertex holds busy high while the face tangent is formed, projected
// against each vertex normal and normalized. Six power-of-two fits (edges,
// UVs, face tangent and the projection of each vertex) shift by one bit per
// step. The per-vertex work is mostly the bit-serial square root and three
// divides of UNIT_WIDTH-1 quotient bits each, all run on one shared MAC and
// one shared bit-serial root/divide unit. A zero UV determinant skips the
// per-vertex work; a vertex whose projection vanishes skips its square root
// and divides. Results come out in vertex order 0, 1, 2, each on the result
// ports for exactly one cycle with done_o high; the receiver cannot stall
// them, so it must take every strobe. last_o marks vertex 2. A zero UV
// determinant, or a projected tangent of zero length, yields degenerate_o
// high and a zero tangent instead of a meaningless value. busy drops in the
// cycle after the last result.
module triangle_tangent_generator #(
  parameter int unsigned COORD_WIDTH = ttg_pkg::COORD_WIDTH_DEF,
  parameter int unsigned UNIT_WIDTH  = ttg_pkg::UNIT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] pos_x_i,
  input  logic [COORD_WIDTH-1:0] pos_y_i,
  input  logic [COORD_WIDTH-1:0] pos_z_i,
  input  logic [COORD_WIDTH-1:0] tex_u_i,
  input  logic [COORD_WIDTH-1:0] tex_v_i,
  input  logic [UNIT_WIDTH-1:0]  norm_x_i,
  input  logic [UNIT_WIDTH-1:0]  norm_y_i,
  input  logic [UNIT_WIDTH-1:0]  norm_z_i,
  output logic                   done_o,
  output logic [UNIT_WIDTH-1:0]  tan_x_o,
  output logic [UNIT_WIDTH-1:0]  tan_y_o,
  output logic [UNIT_WIDTH-1:0]  tan_z_o,
  output logic [1:0]             vertex_slot_o,
  output logic                   degenerate_o,
  output logic                   last_o
);

  // Fraction bits of the unit vectors, and quotient bits of each divide.
  localparam int unsigned UF = UNIT_WIDTH - 2;
  localparam int unsigned QW = UF + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [UNIT_WIDTH-1:0]  unit_t;

  // Vertex store: one entry per vertex of the current triangle.
  coord_t pos_q [3][3];
  coord_t uvs_q [3][2];
  unit_t  nrm_q [3][3];
  unit_t  ncur  [3];

  // Working registers.
  ttg_pkg::work_t vec_q [6];
  ttg_pkg::work_t vec_d [6];
  ttg_pkg::work_t uvd_q [4];
  ttg_pkg::work_t uvd_d [4];
  ttg_pkg::fit_t  e_q   [6];
  ttg_pkg::fit_t  e_d   [6];
  ttg_pkg::fit_t  uv_q  [4];
  ttg_pkg::fit_t  uv_d  [4];
  ttg_pkg::fit_t  t_q   [3];
  ttg_pkg::fit_t  t_d   [3];
  unit_t          tan_q [3];
  unit_t          tan_d [3];
  ttg_pkg::work_t d_q, d_d, l_q, l_d;
  ttg_pkg::mac_a_t dot_q, dot_d;
  logic [ttg_pkg::ROOT_W-1:0] s_q, s_d;

  // Control.
  ttg_pkg::state_e state_q, state_d;
  ttg_pkg::phase_e phase_q, phase_d;
  ttg_pkg::prog_e  prog_q, prog_d;
  logic [1:0]  vcnt_q, vcnt_d, vk_q, vk_d, ci_q, ci_d;
  logic [2:0]  fidx_q, fidx_d, fn_q, fn_d, vidx;
  logic [5:0]  fk_q, fk_d;
  logic        fright_q, fright_d, arm_q, arm_d, degen_q, degen_d;
  logic [3:0]  ms_q, ms_d, nops, jc;
  logic [ttg_pkg::WORK_W-1:0] fm_q, fm_d, vmag;
  logic        accept;

  ttg_pkg::work_t   vrd, acc, acc_sh;
  ttg_pkg::mac_op_t mac_op;
  ttg_pkg::it_req_t it_req;
  logic [ttg_pkg::WORK_W-1:0] it_x, it_d;
  logic [ttg_pkg::ROOT_W-1:0] it_res;
  logic                       it_done;
  logic [UNIT_WIDTH-1:0]      qn;

  assign accept = start && !busy;
  assign busy   = (state_q != ttg_pkg::ST_IDLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ncur[i] = nrm_q[vk_q][i];
    end
  end

  // Single read port into the fit workspace.
  always_comb begin
    case (state_q)
      ttg_pkg::ST_MAC: vidx = ms_q[2:0];
      ttg_pkg::ST_DIV: vidx = {1'b0, ci_q};
      default:         vidx = fidx_q;
    endcase
  end

  assign vrd    = vec_q[vidx];
  assign vmag   = vrd[ttg_pkg::WORK_W-1] ? ttg_pkg::WORK_W'(-vrd) : ttg_pkg::WORK_W'(vrd);
  assign acc_sh = acc >>> UF;
  assign jc     = ms_q - 4'd2;
  assign nops   = (prog_q == ttg_pkg::PG_FACE) ? 4'd8 : 4'd3;
  assign qn     = it_res[UNIT_WIDTH-1:0];

  // MAC program: one product per step.
  always_comb begin
    mac_op     = '0;
    mac_op.go  = (state_q == ttg_pkg::ST_MAC) && (ms_q < nops);
    mac_op.clr = 1'b1;
    case (prog_q)
      ttg_pkg::PG_FACE: begin
        case (ms_q[2:0])
          3'd0: begin
            mac_op.a = ttg_pkg::mac_a_t'(uv_q[0]);
            mac_op.b = ttg_pkg::mac_b_t'(uv_q[3]);
          end
          3'd1: begin
            mac_op.a   = ttg_pkg::mac_a_t'(uv_q[1]);
            mac_op.b   = ttg_pkg::mac_b_t'(uv_q[2]);
            mac_op.clr = 1'b0;
            mac_op.neg = 1'b1;
          end
          3'd2: begin
            mac_op.a = ttg_pkg::mac_a_t'(uv_q[3]);
            mac_op.b = ttg_pkg::mac_b_t'(e_q[0]);
          end
          3'd3: begin
            mac_op.a   = ttg_pkg::mac_a_t'(uv_q[2]);
            mac_op.b   = ttg_pkg::mac_b_t'(e_q[3]);
            mac_op.clr = 1'b0;
            mac_op.neg = 1'b1;
          end
          3'd4: begin
            mac_op.a = ttg_pkg::mac_a_t'(uv_q[3]);
            mac_op.b = ttg_pkg::mac_b_t'(e_q[1]);
          end
          3'd5: begin
            mac_op.a   = ttg_pkg::mac_a_t'(uv_q[2]);
            mac_op.b   = ttg_pkg::mac_b_t'(e_q[4]);
            mac_op.clr = 1'b0;
            mac_op.neg = 1'b1;
          end
          3'd6: begin
            mac_op.a = ttg_pkg::mac_a_t'(uv_q[3]);
            mac_op.b = ttg_pkg::mac_b_t'(e_q[2]);
          end
          default: begin
            mac_op.a   = ttg_pkg::mac_a_t'(uv_q[2]);
            mac_op.b   = ttg_pkg::mac_b_t'(e_q[5]);
            mac_op.clr = 1'b0;
            mac_op.neg = 1'b1;
          end
        endcase
      end
      ttg_pkg::PG_DOT: begin
        mac_op.clr = (ms_q == 4'd0);
        case (ms_q[1:0])
          2'd0: begin
            mac_op.a = ttg_pkg::mac_a_t'(ncur[0]);
            mac_op.b = ttg_pkg::mac_b_t'(t_q[0]);
          end
          2'd1: begin
            mac_op.a = ttg_pkg::mac_a_t'(ncur[1]);
            mac_op.b = ttg_pkg::mac_b_t'(t_q[1]);
          end
          default: begin
            mac_op.a = ttg_pkg::mac_a_t'(ncur[2]);
            mac_op.b = ttg_pkg::mac_b_t'(t_q[2]);
          end
        endcase
      end
      ttg_pkg::PG_PROJ: begin
        mac_op.a = dot_q;
        case (ms_q[1:0])
          2'd0:    mac_op.b = ttg_pkg::mac_b_t'(ncur[0]);
          2'd1:    mac_op.b = ttg_pkg::mac_b_t'(ncur[1]);
          default: mac_op.b = ttg_pkg::mac_b_t'(ncur[2]);
        endcase
      end
      default: begin
        // Squared length of the fitted projection.
        mac_op.clr = (ms_q == 4'd0);
        mac_op.a   = ttg_pkg::mac_a_t'(ttg_pkg::fit_t'(vrd));
        mac_op.b   = ttg_pkg::mac_b_t'(ttg_pkg::fit_t'(vrd));
      end
    endcase
  end

  // Requests to the root/divide unit.
  always_comb begin
    it_req.go   = arm_q && ((state_q == ttg_pkg::ST_SQRT) || (state_q == ttg_pkg::ST_DIV));
    it_req.mode = (state_q == ttg_pkg::ST_SQRT) ? ttg_pkg::IT_SQRT : ttg_pkg::IT_DIV;
    if (state_q == ttg_pkg::ST_SQRT) begin
      it_x = ttg_pkg::WORK_W'(l_q);
    end else begin
      it_x = (vmag << QW) + {{(ttg_pkg::WORK_W - ttg_pkg::ROOT_W){1'b0}}, s_q};
    end
    it_d = {{(ttg_pkg::WORK_W - ttg_pkg::ROOT_W - 1){1'b0}}, s_q, 1'b0};
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    prog_d   = prog_q;
    vcnt_d   = vcnt_q;
    vk_d     = vk_q;
    ci_d     = ci_q;
    fidx_d   = fidx_q;
    fn_d     = fn_q;
    fk_d     = fk_q;
    fright_d = fright_q;
    fm_d     = fm_q;
    ms_d     = ms_q;
    arm_d    = 1'b0;
    degen_d  = degen_q;
    vec_d    = vec_q;
    uvd_d    = uvd_q;
    e_d      = e_q;
    uv_d     = uv_q;
    t_d      = t_q;
    tan_d    = tan_q;
    d_d      = d_q;
    l_d      = l_q;
    dot_d    = dot_q;
    s_d      = s_q;

    case (state_q)
      ttg_pkg::ST_IDLE: begin
        if (accept) begin
          if (vcnt_q == ttg_pkg::LAST_SLOT) begin
            vcnt_d  = '0;
            state_d = ttg_pkg::ST_DELTA;
          end else begin
            vcnt_d = vcnt_q + 2'd1;
          end
        end
      end
      ttg_pkg::ST_DELTA: begin
        for (int i = 0; i < 3; i++) begin
          vec_d[i]     = ttg_pkg::work_t'(pos_q[1][i]) - ttg_pkg::work_t'(pos_q[0][i]);
          vec_d[3 + i] = ttg_pkg::work_t'(pos_q[2][i]) - ttg_pkg::work_t'(pos_q[0][i]);
        end
        uvd_d[0] = ttg_pkg::work_t'(uvs_q[1][0]) - ttg_pkg::work_t'(uvs_q[0][0]);
        uvd_d[1] = ttg_pkg::work_t'(uvs_q[2][0]) - ttg_pkg::work_t'(uvs_q[0][0]);
        uvd_d[2] = ttg_pkg::work_t'(uvs_q[1][1]) - ttg_pkg::work_t'(uvs_q[0][1]);
        uvd_d[3] = ttg_pkg::work_t'(uvs_q[2][1]) - ttg_pkg::work_t'(uvs_q[0][1]);
        phase_d  = ttg_pkg::PH_EDGE;
        fn_d     = 3'd6;
        fidx_d   = '0;
        fm_d     = '0;
        fk_d     = '0;
        fright_d = 1'b0;
        vk_d     = '0;
        degen_d  = 1'b0;
        state_d  = ttg_pkg::ST_FMAX;
      end
      ttg_pkg::ST_FMAX: begin
        // Scan for the largest magnitude in the group.
        if (vmag > fm_q) begin
          fm_d = vmag;
        end
        fidx_d = fidx_q + 3'd1;
        if (fidx_q == fn_q - 3'd1) begin
          fidx_d  = '0;
          state_d = ttg_pkg::ST_FNORM;
        end
      end
      ttg_pkg::ST_FNORM: begin
        // One bit of shift per cycle until the maximum sits in range.
        if (fm_q == '0) begin
          state_d = ttg_pkg::ST_FDONE;
        end else if (fm_q >= ttg_pkg::FIT_HI) begin
          fm_d     = fm_q >> 1;
          fk_d     = fk_q + 6'd1;
          fright_d = 1'b1;
        end else if (fm_q < ttg_pkg::FIT_LO) begin
          fm_d = fm_q << 1;
          fk_d = fk_q + 6'd1;
        end else begin
          state_d = ttg_pkg::ST_FAPPLY;
        end
      end
      ttg_pkg::ST_FAPPLY: begin
        vec_d[fidx_q] = fright_q ? (vrd >>> fk_q) : (vrd <<< fk_q);
        fidx_d = fidx_q + 3'd1;
        if (fidx_q == fn_q - 3'd1) begin
          state_d = ttg_pkg::ST_FDONE;
        end
      end
      ttg_pkg::ST_FDONE: begin
        fidx_d   = '0;
        fm_d     = '0;
        fk_d     = '0;
        fright_d = 1'b0;
        ms_d     = '0;
        case (phase_q)
          ttg_pkg::PH_EDGE: begin
            for (int i = 0; i < 6; i++) begin
              e_d[i] = ttg_pkg::fit_t'(vec_q[i]);
            end
            for (int i = 0; i < 4; i++) begin
              vec_d[i] = uvd_q[i];
            end
            fn_d    = 3'd4;
            phase_d = ttg_pkg::PH_UV;
            state_d = ttg_pkg::ST_FMAX;
          end
          ttg_pkg::PH_UV: begin
            for (int i = 0; i < 4; i++) begin
              uv_d[i] = ttg_pkg::fit_t'(vec_q[i]);
            end
            prog_d  = ttg_pkg::PG_FACE;
            state_d = ttg_pkg::ST_MAC;
          end
          ttg_pkg::PH_TAN: begin
            for (int i = 0; i < 3; i++) begin
              t_d[i] = ttg_pkg::fit_t'(vec_q[i]);
            end
            if (d_q == '0) begin
              degen_d = 1'b1;
              state_d = ttg_pkg::ST_EMIT;
            end else begin
              prog_d  = ttg_pkg::PG_DOT;
              state_d = ttg_pkg::ST_MAC;
            end
          end
          default: begin
            prog_d  = ttg_pkg::PG_LEN;
            state_d = ttg_pkg::ST_MAC;
          end
        endcase
      end
      ttg_pkg::ST_MAC: begin
        ms_d = ms_q + 4'd1;
        // Accumulator lags the issued op by the product and accumulator registers.
        if (ms_q >= 4'd2) begin
          case (prog_q)
            ttg_pkg::PG_FACE: begin
              case (jc)
                4'd1: d_d = acc;
                4'd3: vec_d[0] = d_q[ttg_pkg::WORK_W-1] ? -acc : acc;
                4'd5: vec_d[1] = d_q[ttg_pkg::WORK_W-1] ? -acc : acc;
                4'd7: vec_d[2] = d_q[ttg_pkg::WORK_W-1] ? -acc : acc;
                default: ;
              endcase
            end
            ttg_pkg::PG_DOT: begin
              if (jc == 4'd2) begin
                dot_d = ttg_pkg::mac_a_t'(acc_sh);
              end
            end
            ttg_pkg::PG_PROJ: begin
              vec_d[jc[2:0]] = ttg_pkg::work_t'(t_q[jc[1:0]]) - acc_sh;
            end
            default: begin
              if (jc == 4'd2) begin
                l_d = acc;
              end
            end
          endcase
        end
        if (ms_q == nops + 4'd1) begin
          ms_d = '0;
          case (prog_q)
            ttg_pkg::PG_FACE: begin
              fn_d    = 3'd3;
              phase_d = ttg_pkg::PH_TAN;
              state_d = ttg_pkg::ST_FMAX;
            end
            ttg_pkg::PG_DOT: begin
              prog_d = ttg_pkg::PG_PROJ;
            end
            ttg_pkg::PG_PROJ: begin
              fn_d    = 3'd3;
              phase_d = ttg_pkg::PH_PROJ;
              state_d = ttg_pkg::ST_FMAX;
            end
            default: begin
              if (acc == '0) begin
                degen_d = 1'b1;
                state_d = ttg_pkg::ST_EMIT;
              end else begin
                arm_d   = 1'b1;
                state_d = ttg_pkg::ST_SQRT;
              end
            end
          endcase
        end
      end
      ttg_pkg::ST_SQRT: begin
        if (it_done) begin
          s_d     = it_res;
          ci_d    = '0;
          arm_d   = 1'b1;
          state_d = ttg_pkg::ST_DIV;
        end
      end
      ttg_pkg::ST_DIV: begin
        if (it_done) begin
          tan_d[ci_q] = vrd[ttg_pkg::WORK_W-1] ? -qn : qn;
          if (ci_q == ttg_pkg::LAST_SLOT) begin
            state_d = ttg_pkg::ST_EMIT;
          end else begin
            ci_d  = ci_q + 2'd1;
            arm_d = 1'b1;
          end
        end
      end
      ttg_pkg::ST_EMIT: begin
        if (vk_q == ttg_pkg::LAST_SLOT) begin
          state_d = ttg_pkg::ST_IDLE;
        end else begin
          vk_d = vk_q + 2'd1;
          ms_d = '0;
          if (d_q == '0) begin
            degen_d = 1'b1;
          end else begin
            degen_d = 1'b0;
            prog_d  = ttg_pkg::PG_DOT;
            state_d = ttg_pkg::ST_MAC;
          end
        end
      end
      default: state_d = ttg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ttg_pkg::ST_IDLE;
      phase_q  <= ttg_pkg::PH_EDGE;
      prog_q   <= ttg_pkg::PG_FACE;
      vcnt_q   <= '0;
      vk_q     <= '0;
      ci_q     <= '0;
      fidx_q   <= '0;
      fn_q     <= '0;
      fk_q     <= '0;
      fright_q <= 1'b0;
      ms_q     <= '0;
      arm_q    <= 1'b0;
      degen_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      prog_q   <= prog_d;
      vcnt_q   <= vcnt_d;
      vk_q     <= vk_d;
      ci_q     <= ci_d;
      fidx_q   <= fidx_d;
      fn_q     <= fn_d;
      fk_q     <= fk_d;
      fright_q <= fright_d;
      ms_q     <= ms_d;
      arm_q    <= arm_d;
      degen_q  <= degen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q[vcnt_q][0] <= pos_x_i;
      pos_q[vcnt_q][1] <= pos_y_i;
      pos_q[vcnt_q][2] <= pos_z_i;
      uvs_q[vcnt_q][0] <= tex_u_i;
      uvs_q[vcnt_q][1] <= tex_v_i;
      nrm_q[vcnt_q][0] <= norm_x_i;
      nrm_q[vcnt_q][1] <= norm_y_i;
      nrm_q[vcnt_q][2] <= norm_z_i;
    end
    vec_q <= vec_d;
    uvd_q <= uvd_d;
    e_q   <= e_d;
    uv_q  <= uv_d;
    t_q   <= t_d;
    tan_q <= tan_d;
    d_q   <= d_d;
    l_q   <= l_d;
    dot_q <= dot_d;
    s_q   <= s_d;
    fm_q  <= fm_d;
  end

  ttg_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (acc)
  );

  ttg_root_div #(
    .QW (QW)
  ) u_root_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (it_req),
    .x_i    (it_x),
    .d_i    (it_d),
    .done_o (it_done),
    .res_o  (it_res)
  );

  // Results: zero tangent whenever the vertex is degenerate.
  assign done_o        = (state_q == ttg_pkg::ST_EMIT);
  assign tan_x_o       = degen_q ? '0 : tan_q[0];
  assign tan_y_o       = degen_q ? '0 : tan_q[1];
  assign tan_z_o       = degen_q ? '0 : tan_q[2];
  assign vertex_slot_o = vk_q;
  assign degenerate_o  = degen_q;
  assign last_o        = (vk_q == ttg_pkg::LAST_SLOT);

  `TTG_ASSERT_NEXT(a_idle_after_last, done_o && last_o, !busy, "busy after last result")
  `TTG_ASSERT(a_vcnt_range, vcnt_q != 2'd3, "vertex count out of range")
  `TTG_ASSERT(a_unit_req_state, !it_req.go || busy, "root/divide request while idle")
  `TTG_ASSERT(a_unit_done_state, !it_done || (state_q == ttg_pkg::ST_SQRT) || (state_q == ttg_pkg::ST_DIV), "root/divide result outside its wait state")

endmodule
